[rtl/core/u2cal_pkg.sv]
// Shared constants, types and the month-length table of the seconds-to-date converter.
package u2cal_pkg;

	localparam int unsigned SecsW   = 32;
	localparam int unsigned RemW    = 17;
	localparam int unsigned CountW  = 6;
	localparam int unsigned MonthW  = 6;
	localparam int unsigned DayW    = 11;

	localparam logic [RemW-1:0]   SecsPerDay   = 17'd86400;
	localparam logic [RemW-1:0]   DaysPerCycle = 17'd1461;
	localparam logic [RemW-1:0]   SecsPerHour  = 17'd3600;
	localparam logic [RemW-1:0]   SecsPerMin   = 17'd60;
	localparam logic [11:0]       EpochYear    = 12'd1970;
	localparam logic [MonthW-1:0] LastMonth    = 6'd47;

	localparam logic [4:0] MonthLen [48] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_CYC,
		ST_HOUR,
		ST_MIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		logic [CountW-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic busy;
	} walk_stat_t;

	typedef struct packed {
		logic [1:0] year_off;
		logic [3:0] month;
	} month_split_t;

	function automatic logic [4:0] month_len(input logic [MonthW-1:0] m);
		month_len = MonthLen[m];
	endfunction

	function automatic month_split_t split_month(input logic [MonthW-1:0] m);
		month_split_t r;
		logic [MonthW-1:0] base;
		if (m >= 6'd36) begin
			r.year_off = 2'd3;
			base = 6'd36;
		end else if (m >= 6'd24) begin
			r.year_off = 2'd2;
			base = 6'd24;
		end else if (m >= 6'd12) begin
			r.year_off = 2'd1;
			base = 6'd12;
		end else begin
			r.year_off = 2'd0;
			base = 6'd0;
		end
		r.month = 4'(m - base);
		return r;
	endfunction

endpackage

[rtl/core/u2cal_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module u2cal_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  u2cal_pkg::div_req_t           req,
	input  logic [u2cal_pkg::SecsW-1:0]   dividend,
	input  logic [u2cal_pkg::RemW-1:0]    divisor,
	output u2cal_pkg::div_stat_t          stat,
	output logic [u2cal_pkg::SecsW-1:0]   quotient,
	output logic [u2cal_pkg::RemW-1:0]    remainder
);

	logic [u2cal_pkg::SecsW-1:0]  acc_q;
	logic [u2cal_pkg::RemW-1:0]   rem_q;
	logic [u2cal_pkg::RemW-1:0]   div_q;
	logic [u2cal_pkg::CountW-1:0] cnt_q;
	logic                         done_q;
	logic [u2cal_pkg::RemW:0]     trial;
	logic                         fits;

	assign trial = {rem_q, acc_q[u2cal_pkg::SecsW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.nbits;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == u2cal_pkg::CountW'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - u2cal_pkg::CountW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[u2cal_pkg::SecsW-2:0], fits};
			rem_q <= fits ? u2cal_pkg::RemW'(trial - {1'b0, div_q})
			              : trial[u2cal_pkg::RemW-1:0];
		end
	end

	assign stat.done = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

[rtl/core/u2cal_walk.sv]
// Month walker that subtracts one month length per cycle over the four-year cycle.
module u2cal_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [u2cal_pkg::DayW-1:0]    day_in,
	output u2cal_pkg::walk_stat_t         stat,
	output logic [u2cal_pkg::MonthW-1:0]  month_pos,
	output logic [u2cal_pkg::DayW-1:0]    day_left
);

	logic                          busy_q;
	logic [u2cal_pkg::MonthW-1:0]  m_q;
	logic [u2cal_pkg::DayW-1:0]    day_q;
	logic [4:0]                    len;
	logic                          step;

	assign len  = u2cal_pkg::month_len(m_q);
	assign step = (day_q >= {6'd0, len}) && (m_q != u2cal_pkg::LastMonth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && !step) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q   <= '0;
			day_q <= day_in;
		end else if (busy_q && step) begin
			m_q   <= m_q + u2cal_pkg::MonthW'(1);
			day_q <= day_q - {6'd0, len};
		end
	end

	assign stat.busy = busy_q;
	assign month_pos = m_q;
	assign day_left  = day_q;

endmodule

[rtl/core/unix_seconds_to_calendar_date.sv]
// Top level of the converter from Unix seconds to calendar date and time of day.
//
// One beat on the input channel carries a count of whole seconds since the
// epoch; one beat on the output channel carries the year, month, day of month,
// hour, minute and second. Both channels use valid and stall, and a beat moves
// on a rising edge where valid is high and stall is low.
// The block converts one beat at a time. A shared bit-serial divider first
// splits the seconds into days and time of day, then the days into four-year
// cycles. The month walk, one month per cycle, then runs next to the divisions
// for hour and minute. A new input beat is taken only once the last result
// has been loaded into the output register.
// The result sits in an output register, so the next input beat is taken while
// the receiver stalls; if the receiver still stalls when that next conversion
// ends, the block holds it and keeps in_stall high until the register frees.
// Reset clears the sequencer and the output valid flag; no result is pending after it.
module unix_seconds_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] unix_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] year,
	output logic [3:0]  month_index,
	output logic [4:0]  day_index,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	u2cal_pkg::state_t        state_q, state_d;
	u2cal_pkg::div_req_t      div_req;
	u2cal_pkg::div_stat_t     div_stat;
	u2cal_pkg::walk_stat_t    walk_stat;
	u2cal_pkg::month_split_t  split;

	logic [u2cal_pkg::SecsW-1:0]   div_dividend;
	logic [u2cal_pkg::RemW-1:0]    div_divisor;
	logic [u2cal_pkg::SecsW-1:0]   div_quot;
	logic [u2cal_pkg::RemW-1:0]    div_rem;
	logic                          walk_start;
	logic [u2cal_pkg::MonthW-1:0]  walk_month;
	logic [u2cal_pkg::DayW-1:0]    walk_day;
	logic                          out_load;
	logic                          out_valid_q;

	logic [u2cal_pkg::RemW-1:0]    tod_q;
	logic [5:0]                    cycles_q;
	logic [4:0]                    hour_q;
	logic [5:0]                    minute_q;
	logic [5:0]                    second_q;

	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_out_q;
	logic [5:0]  minute_out_q;
	logic [5:0]  second_out_q;

	u2cal_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	u2cal_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (walk_start),
		.day_in    (div_rem[u2cal_pkg::DayW-1:0]),
		.stat      (walk_stat),
		.month_pos (walk_month),
		.day_left  (walk_day)
	);

	assign split = u2cal_pkg::split_month(walk_month);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u2cal_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		div_req.start = 1'b0;
		div_req.nbits = u2cal_pkg::CountW'(32);
		div_dividend  = unix_seconds;
		div_divisor   = u2cal_pkg::SecsPerDay;
		walk_start    = 1'b0;
		out_load      = 1'b0;
		in_stall      = 1'b1;
		case (state_q)
			u2cal_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					div_req.start = 1'b1;
					state_d       = u2cal_pkg::ST_DAY;
				end
			end
			u2cal_pkg::ST_DAY: begin
				div_dividend  = {div_quot[15:0], 16'd0};
				div_divisor   = u2cal_pkg::DaysPerCycle;
				div_req.nbits = u2cal_pkg::CountW'(16);
				if (div_stat.done) begin
					div_req.start = 1'b1;
					state_d       = u2cal_pkg::ST_CYC;
				end
			end
			u2cal_pkg::ST_CYC: begin
				div_dividend  = {tod_q, 15'd0};
				div_divisor   = u2cal_pkg::SecsPerHour;
				div_req.nbits = u2cal_pkg::CountW'(17);
				if (div_stat.done) begin
					div_req.start = 1'b1;
					walk_start    = 1'b1;
					state_d       = u2cal_pkg::ST_HOUR;
				end
			end
			u2cal_pkg::ST_HOUR: begin
				div_dividend  = {div_rem[11:0], 20'd0};
				div_divisor   = u2cal_pkg::SecsPerMin;
				div_req.nbits = u2cal_pkg::CountW'(12);
				if (div_stat.done) begin
					div_req.start = 1'b1;
					state_d       = u2cal_pkg::ST_MIN;
				end
			end
			u2cal_pkg::ST_MIN: begin
				if (div_stat.done) begin
					state_d = u2cal_pkg::ST_FIN;
				end
			end
			u2cal_pkg::ST_FIN: begin
				if (!walk_stat.busy && (!out_valid_q || !out_stall)) begin
					out_load = 1'b1;
					state_d  = u2cal_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = u2cal_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == u2cal_pkg::ST_DAY && div_stat.done) begin
			tod_q <= div_rem;
		end
		if (state_q == u2cal_pkg::ST_CYC && div_stat.done) begin
			cycles_q <= div_quot[5:0];
		end
		if (state_q == u2cal_pkg::ST_HOUR && div_stat.done) begin
			hour_q <= div_quot[4:0];
		end
		if (state_q == u2cal_pkg::ST_MIN && div_stat.done) begin
			minute_q <= div_quot[5:0];
			second_q <= div_rem[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			year_q       <= u2cal_pkg::EpochYear + {4'd0, cycles_q, 2'b00}
			                + {10'd0, split.year_off};
			month_q      <= split.month;
			day_q        <= walk_day[4:0];
			hour_out_q   <= hour_q;
			minute_out_q <= minute_q;
			second_out_q <= second_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign year        = year_q;
	assign month_index = month_q;
	assign day_index   = day_q;
	assign hour        = hour_out_q;
	assign minute      = minute_out_q;
	assign second      = second_out_q;

endmodule

[tb/tb.sv]
// Self-checking testbench for the Unix-seconds-to-calendar-date converter.
module tb;

	localparam int unsigned RANDOM_BEATS    = 1600;
	localparam int unsigned HOLD_OFF_CYCLES = 1200;
	localparam int unsigned DRAIN_CYCLES    = 250;
	localparam int unsigned CYCLE_LIMIT     = 2000000;

	localparam logic [31:0] EDGE_CASES [25] = '{
		32'd0, 32'd1, 32'd60, 32'd3600, 32'd86399, 32'd86400,
		32'd31535999, 32'd31536000, 32'd63071999, 32'd63072000,
		32'd68169599, 32'd68169600, 32'd68256000, 32'd94694399,
		32'd126230399, 32'd126230400, 32'd951782400,
		32'd4102444799, 32'd4102444800, 32'd4107542400,
		32'd2147483647, 32'h80000000, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF
	};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month_index;
		logic [4:0]  day_index;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} calendar_t;

	class date_checker;
		calendar_t   due_dates[$];
		int unsigned checked;
		int unsigned mismatches;
		int unsigned past_2099;

		static function int unsigned month_len(int unsigned m);
			case (m % 12)
			1:          return (m == 25) ? 29 : 28;
			3, 5, 8, 10: return 30;
			default:    return 31;
			endcase
		endfunction

		static function calendar_t to_calendar(logic [31:0] secs);
			calendar_t   c;
			int unsigned days, tod, cycles, d, m;
			days = secs / 86400;
			tod = secs - days * 86400;
			cycles = days / 1461;
			d = days - cycles * 1461;
			m = 0;
			while (m < 48 && d >= month_len(m)) begin
				d -= month_len(m);
				m++;
			end
			c.year = 12'(1970 + 4 * cycles + m / 12);
			c.month_index = 4'(m % 12);
			c.day_index = 5'(d);
			c.hour = 5'(tod / 3600);
			tod -= (tod / 3600) * 3600;
			c.minute = 6'(tod / 60);
			c.second = 6'(tod % 60);
			return c;
		endfunction

		function void note_input(logic [31:0] secs);
			if (secs > 32'd4102444799)
				past_2099++;
			due_dates.push_back(to_calendar(secs));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(calendar_t got);
			calendar_t want;
			if (due_dates.size() == 0) begin
				$error("output beat with no conversion pending");
				mismatches++;
				return;
			end
			want = due_dates.pop_front();
			checked++;
			compare_field("year", 32'(want.year), 32'(got.year));
			compare_field("month_index", 32'(want.month_index), 32'(got.month_index));
			compare_field("day_index", 32'(want.day_index), 32'(got.day_index));
			compare_field("hour", 32'(want.hour), 32'(got.hour));
			compare_field("minute", 32'(want.minute), 32'(got.minute));
			compare_field("second", 32'(want.second), 32'(got.second));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] unix_seconds;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] year;
	logic [3:0]  month_index;
	logic [4:0]  day_index;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	date_checker book = new();
	int unsigned burst_left;
	int unsigned cycle_count;
	int unsigned held_cycles;
	bit          held_off;

	unix_seconds_to_calendar_date u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.unix_seconds(unix_seconds),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.year        (year),
		.month_index (month_index),
		.day_index   (day_index),
		.hour        (hour),
		.minute      (minute),
		.second      (second)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				book.note_input(unix_seconds);
			if (in_valid && in_stall)
				held_cycles++;
			if (out_valid && !out_stall)
				book.check_result(calendar_t'{year, month_index, day_index, hour, minute,
					second});
		end
	end

	task automatic send_beat(input logic [31:0] value);
		int unsigned gap, pick;
		if (burst_left == 0) begin
			pick = $urandom_range(0, 19);
			if (pick < 10)
				gap = 0;
			else if (pick < 17)
				gap = $urandom_range(1, 10);
			else
				gap = $urandom_range(20, 120);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		unix_seconds <= value;
		do @(posedge clk); while (in_stall);
		burst_left--;
	endtask

	initial begin : receiver
		int unsigned seg, mode, run;
		bit          level;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && book.checked >= 300) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			seg = $urandom_range(10, 300);
			mode = $urandom_range(0, 3);
			run = 0;
			level = 1'b0;
			repeat (seg) begin
				case (mode)
				0: level = 1'b0;
				1: level = 1'($urandom_range(0, 1));
				2: begin
					if (run == 0) begin
						level = !level;
						run = $urandom_range(1, 20);
					end
					run--;
				end
				default: level = ($urandom_range(0, 4) != 0);
				endcase
				out_stall <= level;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned pick, cyc, m, start, days, tod;
		logic [31:0] secs;
		arst_n = 1'b0;
		in_valid = 1'b0;
		unix_seconds = 32'd0;
		burst_left = 0;
		cycle_count = 0;
		held_cycles = 0;
		held_off = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (EDGE_CASES[i])
			send_beat(EDGE_CASES[i]);

		repeat (RANDOM_BEATS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				secs = $urandom_range(0, 32'd4102444799);
			end else if (pick == 4) begin
				secs = $urandom();
			end else if (pick <= 7) begin
				cyc = $urandom_range(0, 33);
				m = $urandom_range(0, 47);
				start = 0;
				for (int k = 0; k < m; k++)
					start += date_checker::month_len(k);
				if ($urandom_range(0, 1))
					start += date_checker::month_len(m) - 1;
				case ($urandom_range(0, 2))
				0:       tod = 0;
				1:       tod = 86399;
				default: tod = $urandom_range(0, 86399);
				endcase
				secs = (cyc * 1461 + start) * 86400 + tod;
			end else if (pick == 8) begin
				days = $urandom_range(1, 49710);
				secs = days * 86400 + $urandom_range(0, 4) - 2;
			end else begin
				secs = 32'hFFFFFFFF - $urandom_range(0, 200000000);
			end
			send_beat(secs);
		end
		in_valid <= 1'b0;

		while (book.due_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted and checked %0d dates, %0d of them past 2099.",
			book.checked, book.past_2099);
		$display("Input was held back for %0d cycles in all, including a long output hold-off.",
			held_cycles);
		if (book.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
